FILE: sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Shared widths, register indexes, frame control bundle and the tick to
// centimetre conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  localparam int unsigned CNT_W  = 11;  // frame counter and echo timing
  localparam int unsigned TRIG_W = 8;   // trigger_end register
  localparam int unsigned DIST_W = 9;   // distance in cm
  localparam int unsigned ECHO_W = 2;   // echo pins carried per tick
  localparam int unsigned CFG_W  = 11;  // widest register
  localparam int unsigned IDX_W  = 2;

  localparam logic [CFG_W-1:0] TRIG_END_RST = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIN_END_RST  = CFG_W'(1900);
  localparam logic [CFG_W-1:0] PERIOD_RST   = CFG_W'(2000);

  // floor(w*17/100) as w*ceil(17*2^22/100) >> 22, exact for all 11-bit w
  localparam int unsigned    MUL_W    = 20;
  localparam int unsigned    CM_SHIFT = 22;
  localparam int unsigned    PROD_W   = CNT_W + MUL_W;
  localparam logic [MUL_W-1:0] CM_MUL = MUL_W'(713032);

  typedef enum logic [IDX_W-1:0] {
    REG_TRIGGER_END = 2'd0,
    REG_WINDOW_END  = 2'd1,
    REG_PERIOD_TOP  = 2'd2
  } uer_reg_e;

  // per-tick frame decode handed to every sensor channel
  typedef struct packed {
    logic             clear;    // count hits trigger_end
    logic             measure;  // trigger_end <= count < window_end
    logic             timeout;  // count hits window_end
    logic [CNT_W-1:0] count;
  } uer_frame_t;

  function automatic logic [DIST_W-1:0] width_to_cm(input logic [CNT_W-1:0] ticks);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(ticks) * PROD_W'(CM_MUL);
    return prod[CM_SHIFT +: DIST_W];
  endfunction

endpackage

`default_nettype wire

FILE: sv/uer_sensor.sv
// ----------------------------------------------------------------------------
// Echo ranger sensor channel
// Times one echo pulse per frame and holds the last distance and its flag.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_sensor (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire uer_pkg::uer_frame_t        frame_i,
  input  wire logic                       echo_i,
  output logic [uer_pkg::DIST_W-1:0]      range_o,
  output logic                            valid_o
);

  logic                       seen_q, seen_d;
  logic                       ended_q, ended_d;
  logic [uer_pkg::CNT_W-1:0]  start_q, start_d;
  logic [uer_pkg::DIST_W-1:0] range_q, range_d;
  logic                       valid_q, valid_d;
  logic [uer_pkg::CNT_W-1:0]  width;

  assign width = frame_i.count - start_q;  // wraps mod 2048

  always_comb begin
    seen_d  = frame_i.clear ? 1'b0 : seen_q;
    ended_d = frame_i.clear ? 1'b0 : ended_q;
    start_d = start_q;
    range_d = range_q;
    valid_d = valid_q;
    if (frame_i.measure) begin
      if (!seen_d) begin
        if (echo_i) begin
          seen_d  = 1'b1;
          start_d = frame_i.count;
        end
      end else if (!ended_d && !echo_i) begin
        ended_d = 1'b1;
        range_d = uer_pkg::width_to_cm(width);
        valid_d = 1'b1;
      end
    end
    // no falling edge inside the window: timeout
    if (frame_i.timeout && !ended_d) begin
      range_d = '0;
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      ended_q <= 1'b0;
      start_q <= '0;
      range_q <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      seen_q  <= seen_d;
      ended_q <= ended_d;
      start_q <= start_d;
      range_q <= range_d;
      valid_q <= valid_d;
    end
  end

  assign range_o = range_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Frame timer, shared trigger and per-sensor echo timing for pulse-echo
// range sensors, one 10 us tick per request.
// ----------------------------------------------------------------------------
// Each input request is one 10 us tick carrying the echo pin levels; each
// tick yields exactly one result request with the trigger drive, the latest
// distance and valid flag of sensors 0 and 1, and a frame_done strobe on the
// tick the measurement window closes. Throughput is one tick per clock cycle
// and a result is ready in the cycle after its tick: the whole update (frame
// decode, echo edge detection, one constant multiply for the cm conversion)
// sits before the state registers, which double as the result register.
// A new tick is taken whenever the result slot is empty or being drained.
// Distances are floor(ticks*17/100) cm, 0 with valid low after a timeout.
// Registers (cfg_idx_i): 0 trigger_end, 1 window_end, 2 period_top; other
// indexes are ignored. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_core #(
  parameter int unsigned NUM_SENSORS = 2   // 1 to 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic [uer_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [uer_pkg::CFG_W-1:0]   cfg_wdata_i,
  // tick stream in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [1:0] echo_levels, zero pad
  // result stream out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] trigger, [9:1] distance_0, [10] valid_0, [19:11] distance_1,
  // [20] valid_1, [21] frame_done, [23:22] zero
  output logic [23:0]                      m_axis_tdata
);

  localparam int unsigned CNT_W  = uer_pkg::CNT_W;
  localparam int unsigned DIST_W = uer_pkg::DIST_W;

  // configuration
  logic [uer_pkg::TRIG_W-1:0] trig_end_q;
  logic [CNT_W-1:0]           win_end_q;
  logic [CNT_W-1:0]           period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_end_q <= uer_pkg::TRIG_W'(uer_pkg::TRIG_END_RST);
      win_end_q  <= CNT_W'(uer_pkg::WIN_END_RST);
      period_q   <= CNT_W'(uer_pkg::PERIOD_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uer_pkg::REG_TRIGGER_END: trig_end_q <= cfg_wdata_i[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_WINDOW_END:  win_end_q  <= cfg_wdata_i[CNT_W-1:0];
        uer_pkg::REG_PERIOD_TOP:  period_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: result slot frees as it is taken
  logic out_valid_q;
  logic accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // frame timer and decode
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    trig_end_ext;
  logic                trig_d, trig_q;
  logic                done_d, done_q;
  uer_pkg::uer_frame_t frame;

  assign trig_end_ext  = CNT_W'(trig_end_q);
  assign trig_d        = count_q < trig_end_ext;
  assign done_d        = count_q == win_end_q;
  assign frame.clear   = count_q == trig_end_ext;
  assign frame.measure = (count_q >= trig_end_ext) && (count_q < win_end_q);
  assign frame.timeout = done_d;
  assign frame.count   = count_q;
  assign count_d       = (count_q >= period_q) ? '0 : count_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      trig_q  <= 1'b0;
      done_q  <= 1'b0;
    end else if (accept) begin
      count_q <= count_d;
      trig_q  <= trig_d;
      done_q  <= done_d;
    end
  end

  // sensor channels
  logic [NUM_SENSORS-1:0][DIST_W-1:0] range;
  logic [NUM_SENSORS-1:0]             valid;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_sensor
    logic echo;
    if (g < uer_pkg::ECHO_W) begin : g_pin
      assign echo = s_axis_tdata[g];
    end else begin : g_nopin
      assign echo = 1'b0;  // no pin in the stream: echo always low
    end
    uer_sensor u_sensor (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .frame_i (frame),
      .echo_i  (echo),
      .range_o (range[g]),
      .valid_o (valid[g])
    );
  end

  logic [DIST_W-1:0] dist_1;
  logic              valid_1;

  if (NUM_SENSORS > 1) begin : g_two
    assign dist_1  = range[1];
    assign valid_1 = valid[1];
  end else begin : g_one
    assign dist_1  = '0;
    assign valid_1 = 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, done_q, valid_1, dist_1, valid[0], range[0], trig_q};

  // checks
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(out_valid_q && !m_axis_tready))
    else $error("tick taken while result stalled");

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (range[0] != '0) |-> valid[0])
    else $error("non-zero distance without valid");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (count_q >= period_q)) |=> (count_q == '0))
    else $error("frame counter failed to wrap");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (count_q == win_end_q)) |=> (done_q && out_valid_q))
    else $error("window close not flagged");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Echo ranger core testbench
// Drives echo-level ticks into the core, predicts trigger, distances, valid
// flags and frame_done per tick, and checks every result request in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import uer_pkg::*;

  localparam int unsigned NUM_SENSORS   = 2;
  localparam int unsigned STALL_LIMIT   = 3000;  // cycles without any request
  localparam int unsigned SETTLE_CYCLES = 3;     // extra wait after the last result is drained
  localparam int unsigned RANDOM_TICKS  = 250;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int          NEVER         = 4096;  // pulse edge past any count
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);

  // one result request, trigger in the lowest bit as on m_axis_tdata
  typedef struct packed {
    logic              frame_done;
    logic              valid_1;
    logic [DIST_W-1:0] distance_1;
    logic              valid_0;
    logic [DIST_W-1:0] distance_0;
    logic              trigger;
  } ranger_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [1:0] echo_levels, zero pad
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] trigger, [9:1] distance_0, [10] valid_0, [19:11] distance_1,
  // [20] valid_1, [21] frame_done, [23:22] zero
  logic [23:0]       m_axis_tdata;

  // predicted core state
  logic [TRIG_W-1:0]      rg_trig_end;
  logic [CNT_W-1:0]       rg_win_end;
  logic [CNT_W-1:0]       rg_period;
  logic [CNT_W-1:0]       rg_count;
  logic [NUM_SENSORS-1:0] rg_seen;
  logic [NUM_SENSORS-1:0] rg_ended;
  logic [NUM_SENSORS-1:0] rg_ok;
  logic [CNT_W-1:0]       rg_start [NUM_SENSORS];
  logic [DIST_W-1:0]      rg_dist  [NUM_SENSORS];

  ranger_result_t expected_ranges[$];
  int unsigned    mismatches    = 0;
  int unsigned    quiet_cycles  = 0;
  int unsigned    ticks_sent    = 0;
  int             stim_count    = 0;  // frame count as the sender tracks it
  int unsigned    src_idle_pct  = 0;
  int unsigned    snk_stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ultrasonic_echo_ranger_core #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void reset_ranger();
    int n;
    rg_trig_end = TRIG_END_RST[TRIG_W-1:0];
    rg_win_end  = WIN_END_RST[CNT_W-1:0];
    rg_period   = PERIOD_RST[CNT_W-1:0];
    rg_count    = '0;
    rg_seen     = '0;
    rg_ended    = '0;
    rg_ok       = '0;
    for (n = 0; n < NUM_SENSORS; n++) begin
      rg_start[n] = '0;
      rg_dist[n]  = '0;
    end
  endfunction

  // one tick: frame decode, echo timing, timeout, then the counter advance
  function automatic ranger_result_t ranger_tick(input logic [ECHO_W-1:0] echo);
    ranger_result_t   res;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] trig_end;
    logic [CNT_W-1:0] width;
    int               n;
    c        = rg_count;
    trig_end = CNT_W'(rg_trig_end);
    res      = '0;
    res.trigger = (c < trig_end);
    if (c == trig_end) begin
      rg_seen  = '0;
      rg_ended = '0;
    end
    if (c >= trig_end && c < rg_win_end) begin
      for (n = 0; n < NUM_SENSORS; n++) begin
        if (!rg_seen[n]) begin
          if (echo[n]) begin
            rg_seen[n]  = 1'b1;
            rg_start[n] = c;
          end
        end else if (!rg_ended[n] && !echo[n]) begin
          // pulse width wraps at the counter width, 17/100 cm per tick
          width       = c - rg_start[n];
          rg_ended[n] = 1'b1;
          rg_dist[n]  = DIST_W'((32'(width) * 17) / 100);
          rg_ok[n]    = 1'b1;
        end
      end
    end
    if (c == rg_win_end) begin
      res.frame_done = 1'b1;
      for (n = 0; n < NUM_SENSORS; n++) begin
        if (!rg_ended[n]) begin
          rg_ok[n]   = 1'b0;
          rg_dist[n] = '0;
        end
      end
    end
    res.distance_0 = rg_dist[0];
    res.valid_0    = rg_ok[0];
    res.distance_1 = rg_dist[1];
    res.valid_1    = rg_ok[1];
    rg_count = (c >= rg_period) ? '0 : c + 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    // keep the log bounded when the core is badly off
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // config, tick requests and result requests all seen at the same edge
  always @(posedge clk_i) begin
    ranger_result_t got;
    ranger_result_t want;
    if (!rst_ni) begin
      reset_ranger();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TRIGGER_END: rg_trig_end = cfg_wdata_i[TRIG_W-1:0];
          REG_WINDOW_END:  rg_win_end  = cfg_wdata_i[CNT_W-1:0];
          REG_PERIOD_TOP:  rg_period   = cfg_wdata_i[CNT_W-1:0];
          default: ;  // no register behind this index
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_ranges.push_back(ranger_tick(s_axis_tdata[ECHO_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(ranger_result_t)-1:0];
        if (m_axis_tdata[23:$bits(ranger_result_t)] != '0)
          report_mismatch("pad bits", 32'(m_axis_tdata[23:$bits(ranger_result_t)]), 0);
        if (expected_ranges.size() == 0) begin
          report_mismatch("result with no tick pending", 32'(got), 0);
        end else begin
          want = expected_ranges.pop_front();
          if (got.trigger !== want.trigger)
            report_mismatch("trigger", 32'(got.trigger), 32'(want.trigger));
          if (got.distance_0 !== want.distance_0)
            report_mismatch("distance_0", 32'(got.distance_0), 32'(want.distance_0));
          if (got.valid_0 !== want.valid_0)
            report_mismatch("valid_0", 32'(got.valid_0), 32'(want.valid_0));
          if (got.distance_1 !== want.distance_1)
            report_mismatch("distance_1", 32'(got.distance_1), 32'(want.distance_1));
          if (got.valid_1 !== want.valid_1)
            report_mismatch("valid_1", 32'(got.valid_1), 32'(want.valid_1));
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

  // watchdog: give up once no request moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // valid stays high from one request to the next unless a gap is drawn
  task automatic send_tick(input logic [ECHO_W-1:0] echo);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(8-ECHO_W){1'b0}}, echo};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    stim_count = (stim_count >= int'(rg_period)) ? 0 : stim_count + 1;
  endtask

  // drain every pending result before touching the registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_ranges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_frame(input int trig_end, input int win_end, input int period);
    settle();
    write_reg(REG_TRIGGER_END, CFG_W'(trig_end));
    write_reg(REG_WINDOW_END, CFG_W'(win_end));
    write_reg(REG_PERIOD_TOP, CFG_W'(period));
  endtask

  // ticks up to the wrap; sensor n echoes high for counts [rise, fall)
  task automatic send_frame(input int rise0, input int fall0,
                            input int rise1, input int fall1);
    logic [ECHO_W-1:0] echo;
    do begin
      echo[0] = (stim_count >= rise0) && (stim_count < fall0);
      echo[1] = (stim_count >= rise1) && (stim_count < fall1);
      send_tick(echo);
    end while (stim_count != 0);
  endtask

  // clean pulse per sensor: silent, unterminated or of random width
  task automatic send_random_frame();
    int rise [2];
    int fall [2];
    int n;
    for (n = 0; n < 2; n++) begin
      rise[n] = $urandom_range(rg_period);
      fall[n] = rise[n] + $urandom_range(int'(rg_period) + 1, 1);
      case ($urandom_range(5))
        0: rise[n] = NEVER;
        1: fall[n] = NEVER;
        default: ;
      endcase
    end
    send_frame(rise[0], fall[0], rise[1], fall[1]);
  endtask

  task automatic send_noise_frame();
    do send_tick(ECHO_W'($urandom_range(3))); while (stim_count != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset registers: trigger high for counts 0 and 1, echoes around the clear
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_tick(2'b11);
    send_tick(2'b11);
    send_tick(2'b00);
    send_tick(2'b01);
    send_tick(2'b10);
    send_tick(2'b00);
  endtask

  // count sits above the new period and must wrap; trigger_end is masked to
  // 8 bits and the spare index is ignored
  task automatic test_period_lowered();
    settle();
    write_reg(REG_TRIGGER_END, 11'h701);
    write_reg(REG_UNUSED, 11'h7FF);
    write_reg(REG_WINDOW_END, 11'd3);
    write_reg(REG_PERIOD_TOP, 11'd3);
    send_frame(NEVER, NEVER, NEVER, NEVER);
    send_frame(1, 2, 1, NEVER);
    send_frame(0, 2, 2, 3);
  endtask

  // window closing before the trigger ends: the timeout sees flags from the
  // previous frame first, then the cleared ones
  task automatic test_stale_flags();
    set_frame(1, 2, 2);
    send_frame(1, 2, 1, 2);
    set_frame(3, 1, 5);
    send_frame(0, 6, 0, 6);
    send_frame(0, 6, 0, 6);
  endtask

  // window past the period: no timeout and no frame_done
  task automatic test_window_past_period();
    set_frame(1, 9, 6);
    set_idling(57, 57);
    send_frame(1, 4, 2, NEVER);
    send_frame(3, 5, 0, 3);
    set_idling(0, 0);
  endtask

  task automatic test_trigger_end_max();
    set_frame(255, 262, 270);
    send_frame(200, 259, 255, NEVER);
  endtask

  // long frame: wide pulse on sensor 0, sensor 1 never falls and times out
  task automatic test_longest_frame();
    set_frame(1, 120, 120);
    set_idling(18, 18);
    send_frame(0, 119, 60, NEVER);
    set_idling(0, 0);
  endtask

  // all registers zero: counter parked at 0, clear and timeout every tick
  task automatic test_zero_registers();
    set_frame(0, 0, 0);
    send_tick(2'b01);
    send_tick(2'b10);
    send_tick(2'b11);
    send_tick(2'b00);
  endtask

  // mostly clean pulses over small random frames, some noise frames
  task automatic test_random_frames();
    int unsigned target;
    int          phase;
    int          te;
    int          we;
    int          pt;
    target = ticks_sent + RANDOM_TICKS;
    phase  = 0;
    while (ticks_sent < target || phase < 4) begin
      case ($urandom_range(5))
        0: begin  // window not after trigger end
          te = $urandom_range(20, 2);
          we = $urandom_range(te);
          pt = $urandom_range(40, te);
        end
        1: begin  // window beyond period
          pt = $urandom_range(30, 2);
          we = $urandom_range(pt + 12, pt + 1);
          te = $urandom_range(pt, 1);
        end
        default: begin
          te = $urandom_range(8, 1);
          we = te + $urandom_range(40, 1);
          pt = we + $urandom_range(8);
        end
      endcase
      set_frame(te, we, pt);
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(57, 0);
        2: set_idling(0, 57);
        default: set_idling(18, 18);
      endcase
      repeat ($urandom_range(5, 2)) begin
        if ($urandom_range(4) == 0)
          send_noise_frame();
        else
          send_random_frame();
      end
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_period_lowered();
    test_stale_flags();
    test_window_past_period();
    test_trigger_end_max();
    test_longest_frame();
    test_zero_registers();
    test_random_frames();
    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
